@@ design/assert_macros.svh @@
// Assertion macros used by the top design file of the message sequencer.
// Self-contained; the bodies are left empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ design/smsq_pkg.sv @@
// Shared types, constants and helpers of the scrolling message sequencer.
// No dependencies.
package smsq_pkg;

  // Queue storage and field widths
  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_CHARS   = 64;
  localparam int CHAR_PIXELS = 6;
  localparam int GAP_CHARS   = 2;
  localparam int HANDLE_W    = 8;
  localparam int LEN_W       = 6;
  localparam int PRIO_W      = 8;
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 8;
  localparam int WIDTH_W     = 10;
  localparam int LIMIT_W     = 4;
  localparam int OFFSET_W    = 11;
  localparam int SUM_W       = OFFSET_W + 1;

  localparam logic [PRIO_W-1:0]   FRONT_PRIORITY = PRIO_W'(2);
  localparam logic [SUM_W-1:0]    GAP_PIXELS     = SUM_W'(GAP_CHARS * CHAR_PIXELS);
  localparam logic [OFFSET_W-1:0] SCROLL_MAX     = '1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd3;

  // Reset values of the configuration registers
  localparam logic [SPEED_W-1:0] RST_STEP_PX      = SPEED_W'(1);
  localparam logic [TIME_W-1:0]  RST_TIMEOUT_MS   = TIME_W'(5000);
  localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT  = LIMIT_W'(8);
  localparam logic [WIDTH_W-1:0] RST_SCREEN_WIDTH = WIDTH_W'(240);

  // Configuration as seen by the engine; limit already clamped to 1..QUEUE_DEPTH
  typedef struct packed {
    logic [SPEED_W-1:0] step_px;
    logic [TIME_W-1:0]  timeout_ms;
    logic [CNT_W-1:0]   limit;
    logic [WIDTH_W-1:0] screen_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] msg_handle;
    logic [LEN_W-1:0]    msg_length;
    logic [PRIO_W-1:0]   priority_req;
    logic [TIME_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic                showing;
    logic [HANDLE_W-1:0] shown_handle;
    logic [LEN_W-1:0]    shown_length;
    logic [OFFSET_W-1:0] scroll_offset;
    logic                second_copy;
    logic [CNT_W-1:0]    queue_count;
  } result_t;

  // Ring successor: wraps to 0 when the next slot would reach the limit
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] limit);
    logic [CNT_W:0] succ;
    succ = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
    next_idx = (succ >= (CNT_W+1)'(limit)) ? '0 : succ[IDX_W-1:0];
  endfunction

endpackage

@@ design/scrolling_message_sequencer_unit.sv @@
// Pipeline: an accepted item waits in the input register; its result loads the
// result register once that register is free, and a result-channel stall holds
// both. Throughput: one item per cycle while out_stall_i is low, set by
// the queue and scroll update in smsq_engine feeding its own state. Reset
// (async, active low) empties the queue, clears the started bits and scroll,
// and loads the configuration defaults; entry text fields are undefined until
// pushed. Depends on smsq_pkg, smsq_cfg_regs, smsq_engine, assert_macros.svh.
`include "assert_macros.svh"

module scrolling_message_sequencer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           kind_i,
  input  logic [smsq_pkg::HANDLE_W-1:0]        msg_handle_i,
  input  logic [smsq_pkg::LEN_W-1:0]           msg_length_i,
  input  logic [smsq_pkg::PRIO_W-1:0]          priority_req_i,
  input  logic [smsq_pkg::TIME_W-1:0]          now_ms_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 showing_o,
  output logic [smsq_pkg::HANDLE_W-1:0]        shown_handle_o,
  output logic [smsq_pkg::LEN_W-1:0]           shown_length_o,
  output logic [smsq_pkg::OFFSET_W-1:0]        scroll_offset_o,
  output logic                                 second_copy_o,
  output logic [smsq_pkg::CNT_W-1:0]           queue_count_o,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [smsq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [smsq_pkg::TIME_W-1:0]          cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  smsq_pkg::item_t   item_q;
  logic              out_valid_q, out_valid_d;
  smsq_pkg::result_t res_q;
  smsq_pkg::result_t res_comb;
  smsq_pkg::cfg_t    cfg;
  logic              out_free, fire, in_take;

  // Handshake: result register frees when empty or taken this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_valid_d  = in_take || (in_valid_q && !fire);
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind         <= kind_i;
      item_q.msg_handle   <= msg_handle_i;
      item_q.msg_length   <= msg_length_i;
      item_q.priority_req <= priority_req_i;
      item_q.now_ms       <= now_ms_i;
    end
    if (fire) begin
      res_q <= res_comb;
    end
  end

  smsq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  smsq_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_comb)
  );

  assign out_valid_o     = out_valid_q;
  assign showing_o       = res_q.showing;
  assign shown_handle_o  = res_q.shown_handle;
  assign shown_length_o  = res_q.shown_length;
  assign scroll_offset_o = res_q.scroll_offset;
  assign second_copy_o   = res_q.second_copy;
  assign queue_count_o   = res_q.queue_count;

  // Checks
  `ASSERT_PROP(a_idle_result_zero, clk_i, rst_ni, (out_valid_o && !showing_o) |-> (scroll_offset_o == '0 && !second_copy_o && shown_handle_o == '0))
  `ASSERT_PROP(a_count_in_range, clk_i, rst_ni, out_valid_o |-> (queue_count_o <= smsq_pkg::CNT_W'(smsq_pkg::QUEUE_DEPTH)))
  `ASSERT_PROP(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> (in_valid_q && out_valid_q))

endmodule

@@ design/smsq_cfg_regs.sv @@
// Configuration register file of the message sequencer.
// Depends on smsq_pkg.
module smsq_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [smsq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [smsq_pkg::TIME_W-1:0]           cfg_data_i,
  output smsq_pkg::cfg_t                        cfg_o
);

  logic [smsq_pkg::SPEED_W-1:0] speed_q;
  logic [smsq_pkg::TIME_W-1:0]  timeout_q;
  logic [smsq_pkg::LIMIT_W-1:0] limit_q;
  logic [smsq_pkg::WIDTH_W-1:0] width_q;

  // Register writes, one per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= smsq_pkg::RST_STEP_PX;
      timeout_q <= smsq_pkg::RST_TIMEOUT_MS;
      limit_q   <= smsq_pkg::RST_QUEUE_LIMIT;
      width_q   <= smsq_pkg::RST_SCREEN_WIDTH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        smsq_pkg::CFG_STEP_PX:      speed_q   <= cfg_data_i[smsq_pkg::SPEED_W-1:0];
        smsq_pkg::CFG_TIMEOUT_MS:   timeout_q <= cfg_data_i;
        smsq_pkg::CFG_QUEUE_LIMIT:  limit_q   <= cfg_data_i[smsq_pkg::LIMIT_W-1:0];
        smsq_pkg::CFG_SCREEN_WIDTH: width_q   <= cfg_data_i[smsq_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limit: zero acts as one, anything above the depth acts as the depth
  always_comb begin
    cfg_o.step_px      = speed_q;
    cfg_o.timeout_ms   = timeout_q;
    cfg_o.screen_width = width_q;
    if (limit_q == '0) begin
      cfg_o.limit = smsq_pkg::CNT_W'(1);
    end else if (smsq_pkg::CNT_W'(limit_q) > smsq_pkg::CNT_W'(smsq_pkg::QUEUE_DEPTH)) begin
      cfg_o.limit = smsq_pkg::CNT_W'(smsq_pkg::QUEUE_DEPTH);
    end else begin
      cfg_o.limit = smsq_pkg::CNT_W'(limit_q);
    end
  end

endmodule

@@ design/smsq_engine.sv @@
// Queue state, entry storage and combinational item processing of the sequencer.
// Depends on smsq_pkg.
module smsq_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  smsq_pkg::item_t   item_i,
  input  smsq_pkg::cfg_t    cfg_i,
  output smsq_pkg::result_t result_o
);

  localparam int D     = smsq_pkg::QUEUE_DEPTH;
  localparam int IDX_W = smsq_pkg::IDX_W;
  localparam int CNT_W = smsq_pkg::CNT_W;
  localparam int SUM_W = smsq_pkg::SUM_W;

  // Entry storage
  logic [smsq_pkg::HANDLE_W-1:0] handle_q [D];
  logic [smsq_pkg::LEN_W-1:0]    length_q [D];
  logic [smsq_pkg::TIME_W-1:0]   stamp_q  [D];
  logic [D-1:0]                  started_q;
  logic [D-1:0]                  started_d;

  // Queue control
  logic [IDX_W-1:0]              wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [smsq_pkg::OFFSET_W-1:0] pos_q, pos_d;

  // Per-item working values
  logic                          put_en;
  logic [IDX_W-1:0]              put_slot;
  logic [D-1:0]                  start_mask;
  logic [IDX_W-1:0]              rd_next, rd_after, ins_slot;
  logic [CNT_W-1:0]              cnt_after;
  logic                          head_started;
  logic [smsq_pkg::TIME_W-1:0]   head_stamp, elapsed;
  logic [smsq_pkg::LEN_W-1:0]    head_len;
  logic [SUM_W-1:0]              text_px, sum;
  logic                          wide;

  always_comb begin
    wr_d         = wr_q;
    rd_d         = rd_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    result_o     = '0;
    put_en       = 1'b0;
    put_slot     = wr_q;
    start_mask   = '0;
    rd_next      = smsq_pkg::next_idx(rd_q, cfg_i.limit);
    rd_after     = rd_q;
    cnt_after    = cnt_q;
    ins_slot     = '0;
    head_started = started_q[rd_q];
    head_stamp   = head_started ? stamp_q[rd_q] : item_i.now_ms;
    elapsed      = item_i.now_ms - head_stamp;
    head_len     = '0;
    text_px      = '0;
    sum          = '0;
    wide         = 1'b0;

    case (item_i.kind)
      smsq_pkg::KIND_PUSH: begin
        // A full queue drops its oldest entry first
        if (cnt_q >= cfg_i.limit && cnt_q != '0) begin
          rd_after  = rd_next;
          cnt_after = cnt_q - CNT_W'(1);
        end
        put_en = 1'b1;
        if (item_i.priority_req >= smsq_pkg::FRONT_PRIORITY) begin
          // Insert in front of the head and restart the scroll
          ins_slot = (rd_after == '0) ? IDX_W'(cfg_i.limit - CNT_W'(1))
                                      : rd_after - IDX_W'(1);
          put_slot = ins_slot;
          rd_d     = ins_slot;
          pos_d    = '0;
        end else begin
          put_slot = wr_q;
          wr_d     = smsq_pkg::next_idx(wr_q, cfg_i.limit);
          rd_d     = rd_after;
        end
        // The 6-bit length never exceeds MAX_CHARS-1, so no clamp is needed
        cnt_d = cnt_after + CNT_W'(1);
        if (cnt_d == CNT_W'(1)) begin
          pos_d            = '0;
          start_mask[rd_d] = 1'b1;
        end
      end

      smsq_pkg::KIND_CLEAR: begin
        wr_d  = '0;
        rd_d  = '0;
        cnt_d = '0;
        pos_d = '0;
      end

      smsq_pkg::KIND_TICK: begin
        if (cnt_q != '0) begin
          // Start the head on its first tick
          if (!head_started) begin
            start_mask[rd_q] = 1'b1;
            pos_d            = '0;
          end
          // Timeout pops the head and starts the next one
          if (cfg_i.timeout_ms != '0 && elapsed > cfg_i.timeout_ms) begin
            rd_d  = rd_next;
            cnt_d = cnt_q - CNT_W'(1);
            pos_d = '0;
            if (cnt_d != '0) begin
              start_mask[rd_next] = 1'b1;
            end
          end
          if (cnt_d != '0) begin
            head_len = length_q[rd_d];
            text_px  = SUM_W'(head_len) * SUM_W'(smsq_pkg::CHAR_PIXELS);
            wide     = text_px > SUM_W'(cfg_i.screen_width);
            result_o.showing       = 1'b1;
            result_o.shown_handle  = handle_q[rd_d];
            result_o.shown_length  = head_len;
            result_o.scroll_offset = pos_d;
            result_o.second_copy   = wide;
            // Advance the scroll: narrow text pops once off screen, wide text wraps
            sum = SUM_W'(pos_d) + SUM_W'(cfg_i.step_px);
            if (!wide) begin
              if (sum > text_px + SUM_W'(cfg_i.screen_width)) begin
                rd_after = smsq_pkg::next_idx(rd_d, cfg_i.limit);
                rd_d     = rd_after;
                cnt_d    = cnt_d - CNT_W'(1);
                sum      = '0;
                if (cnt_d != '0) begin
                  start_mask[rd_after] = 1'b1;
                end
              end
            end else if (sum >= text_px + smsq_pkg::GAP_PIXELS) begin
              sum = '0;
            end
            pos_d = (sum > SUM_W'(smsq_pkg::SCROLL_MAX)) ? smsq_pkg::SCROLL_MAX
                                                         : sum[smsq_pkg::OFFSET_W-1:0];
          end
        end
      end

      default: ;
    endcase

    result_o.queue_count = cnt_d;
  end

  // Started bits: a put clears, a start sets (a start wins on the same slot)
  always_comb begin
    started_d = started_q;
    for (int j = 0; j < D; j++) begin
      if (put_en && put_slot == IDX_W'(j)) begin
        started_d[j] = 1'b0;
      end
      if (start_mask[j]) begin
        started_d[j] = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      started_q <= '0;
    end else if (fire_i) begin
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      started_q <= started_d;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int j = 0; j < D; j++) begin
        if (put_en && put_slot == IDX_W'(j)) begin
          handle_q[j] <= item_i.msg_handle;
          length_q[j] <= item_i.msg_length;
        end
        if (start_mask[j]) begin
          stamp_q[j] <= item_i.now_ms;
        end
      end
    end
  end

endmodule
